// ===== rtl/core/rc5_pkg.sv =====
// rc5 frame decoder package: status codes and the window match flags
// shared by the decoder modules. no dependencies.
package rc5_pkg;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_COUNT = 2'd1,
    ST_BAD_DUR   = 2'd2,
    ST_BAD_START = 2'd3
  } rc5_status_t;

  // window results for one symbol
  typedef struct packed {
    logic d0_half;
    logic d0_full;
    logic d1_half;
    logic d1_full;
  } rc5_match_t;

  localparam int DurW      = 15;
  localparam int PeriodW   = 14;
  localparam int CountW    = 5;
  localparam int FrameW    = 16;
  localparam int MinSymbols = 7;

endpackage

// ===== rtl/core/rc5_chan_if.sv =====
// valid/ready channel interfaces for the rc5 frame decoder: symbol input
// and frame result. no dependencies.
interface rc5_sym_if;
  logic        valid;
  logic        ready;
  logic [14:0] first_duration;
  logic [14:0] second_duration;
  logic        first_level;
  logic        last_symbol;

  modport source (output valid, first_duration, second_duration, first_level,
                  last_symbol, input ready);
  modport sink (input valid, first_duration, second_duration, first_level,
                last_symbol, output ready);
endinterface

interface rc5_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        repeat_flag;
  logic        toggle_bit;
  logic [4:0]  device_address;
  logic [5:0]  command_code;
  logic [15:0] raw_frame;

  modport source (output valid, status, repeat_flag, toggle_bit, device_address,
                  command_code, raw_frame, input ready);
  modport sink (input valid, status, repeat_flag, toggle_bit, device_address,
                command_code, raw_frame, output ready);
endinterface

// ===== rtl/core/rc5_cfg_regs.sv =====
// apb-style register block for the rc5 frame decoder: half period and
// tolerance. depends on rc5_pkg.
module rc5_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [rc5_pkg::PeriodW-1:0] half_period,
  output logic [rc5_pkg::PeriodW-1:0] tolerance
);
  import rc5_pkg::*;

  localparam logic REG_HALF = 1'b0;
  localparam logic REG_TOL  = 1'b1;

  logic [PeriodW-1:0] half_period_r;
  logic [PeriodW-1:0] tolerance_r;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= PeriodW'(889);
      tolerance_r   <= PeriodW'(450);
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_HALF: half_period_r <= pwdata[PeriodW-1:0];
        REG_TOL:  tolerance_r   <= pwdata[PeriodW-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_HALF: prdata = 32'(half_period_r);
      REG_TOL:  prdata = 32'(tolerance_r);
      default:  prdata = '0;
    endcase
  end

  assign half_period = half_period_r;
  assign tolerance   = tolerance_r;

endmodule

// ===== rtl/core/rc5_win_match.sv =====
// duration window compares for one symbol: each duration against the half
// and the full period. depends on rc5_pkg.
module rc5_win_match (
  input  logic [rc5_pkg::DurW-1:0]    first_duration,
  input  logic [rc5_pkg::DurW-1:0]    second_duration,
  input  logic [rc5_pkg::PeriodW-1:0] half_period,
  input  logic [rc5_pkg::PeriodW-1:0] tolerance,
  output rc5_pkg::rc5_match_t         match
);
  import rc5_pkg::*;

  // open window (e - t, e + t); empty when t exceeds e
  function automatic logic in_win(input logic [DurW-1:0] d,
                                  input logic [DurW-1:0] e,
                                  input logic [PeriodW-1:0] t);
    logic [DurW:0] lo;
    logic [DurW:0] hi;
    lo = (DurW+1)'(e) - (DurW+1)'(t);
    hi = (DurW+1)'(e) + (DurW+1)'(t);
    if (DurW'(t) > e) begin
      return 1'b0;
    end
    return ((DurW+1)'(d) > lo) && ((DurW+1)'(d) < hi);
  endfunction

  logic [DurW-1:0] exp_half;
  logic [DurW-1:0] exp_full;

  assign exp_half = DurW'(half_period);
  assign exp_full = {half_period, 1'b0};

  always_comb begin
    match.d0_half = in_win(first_duration, exp_half, tolerance);
    match.d0_full = in_win(first_duration, exp_full, tolerance);
    match.d1_half = in_win(second_duration, exp_half, tolerance);
    match.d1_full = in_win(second_duration, exp_full, tolerance);
  end

endmodule

// ===== rtl/core/rc5_frame_acc.sv =====
// symbol register, frame accumulator and result register of the rc5 frame
// decoder. depends on rc5_pkg and rc5_res_if.
module rc5_frame_acc #(
  parameter int MAX_SYMBOLS = 30
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rc5_pkg::rc5_match_t in_match,
  input  logic                in_level,
  input  logic                in_last,
  rc5_res_if.source           out_res
);
  import rc5_pkg::*;

  localparam logic [CountW-1:0] CountSat = '1;

  // symbol register
  logic        s1_vld_r;
  rc5_match_t  s1_match_r;
  logic        s1_level_r;
  logic        s1_last_r;
  logic        s1_adv;

  // per-frame state
  logic [FrameW-1:0] shift_r, shift_nxt;
  logic              phase_r, phase_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic              err_r, err_nxt;

  // last good frame
  logic        prev_vld_r;
  logic        prev_tog_r;
  logic [4:0]  prev_adr_r;
  logic [5:0]  prev_cmd_r;

  // result register
  logic              out_vld_r;
  rc5_status_t       status_r, status_nxt;
  logic              rep_r, rep_nxt;
  logic              tog_r, tog_nxt;
  logic [4:0]        adr_r, adr_nxt;
  logic [5:0]        cmd_r, cmd_nxt;
  logic [FrameW-1:0] raw_r, raw_nxt;

  logic out_free;

  assign out_free = !out_vld_r || out_res.ready;
  // only a closing symbol needs the result register
  assign s1_adv   = s1_vld_r && (!s1_last_r || out_free);
  assign in_ready = !s1_vld_r || s1_adv;

  always_comb begin
    shift_nxt = shift_r;
    phase_nxt = phase_r;
    err_nxt   = err_r;
    if (!err_r) begin
      if (s1_match_r.d0_half) begin
        shift_nxt = {shift_r[FrameW-2:0], phase_r};
        if (s1_match_r.d1_full) begin
          phase_nxt = ~phase_r;
        end
      end else if (s1_match_r.d0_full) begin
        shift_nxt = {shift_r[FrameW-3:0], s1_level_r, ~s1_level_r};
        if (s1_match_r.d1_half) begin
          phase_nxt = ~phase_r;
        end
      end else begin
        err_nxt = 1'b1;
      end
    end
    count_nxt = (count_r < CountSat) ? count_r + 1'b1 : count_r;

    raw_nxt = shift_nxt;
    tog_nxt = shift_nxt[11];
    adr_nxt = shift_nxt[10:6];
    cmd_nxt = shift_nxt[5:0];
    priority if (count_nxt < CountW'(MinSymbols) || count_nxt > CountW'(MAX_SYMBOLS)) begin
      status_nxt = ST_BAD_COUNT;
    end else if (err_nxt) begin
      status_nxt = ST_BAD_DUR;
    end else if (shift_nxt[13:12] != 2'b11) begin
      status_nxt = ST_BAD_START;
    end else begin
      status_nxt = ST_OK;
    end
    rep_nxt = prev_vld_r && (tog_nxt == prev_tog_r) && (adr_nxt == prev_adr_r)
              && (cmd_nxt == prev_cmd_r);
    if (status_nxt != ST_OK) begin
      rep_nxt = 1'b0;
      tog_nxt = 1'b0;
      adr_nxt = '0;
      cmd_nxt = '0;
      raw_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      shift_r    <= '0;
      phase_r    <= 1'b0;
      count_r    <= '0;
      err_r      <= 1'b0;
      prev_vld_r <= 1'b0;
      prev_tog_r <= 1'b0;
      prev_adr_r <= '0;
      prev_cmd_r <= '0;
    end else begin
      if (in_ready) begin
        s1_vld_r <= in_valid;
      end
      if (in_valid && in_ready) begin
        s1_match_r <= in_match;
        s1_level_r <= in_level;
        s1_last_r  <= in_last;
      end

      if (out_vld_r && out_res.ready && !(s1_adv && s1_last_r)) begin
        out_vld_r <= 1'b0;
      end

      if (s1_adv) begin
        if (s1_last_r) begin
          out_vld_r <= 1'b1;
          status_r  <= status_nxt;
          rep_r     <= rep_nxt;
          tog_r     <= tog_nxt;
          adr_r     <= adr_nxt;
          cmd_r     <= cmd_nxt;
          raw_r     <= raw_nxt;
          shift_r   <= '0;
          phase_r   <= 1'b0;
          count_r   <= '0;
          err_r     <= 1'b0;
          if (status_nxt == ST_OK) begin
            prev_vld_r <= 1'b1;
            prev_tog_r <= tog_nxt;
            prev_adr_r <= adr_nxt;
            prev_cmd_r <= cmd_nxt;
          end
        end else begin
          shift_r <= shift_nxt;
          phase_r <= phase_nxt;
          count_r <= count_nxt;
          err_r   <= err_nxt;
        end
      end
    end
  end

  assign out_res.valid          = out_vld_r;
  assign out_res.status         = status_r;
  assign out_res.repeat_flag    = rep_r;
  assign out_res.toggle_bit     = tog_r;
  assign out_res.device_address = adr_r;
  assign out_res.command_code   = cmd_r;
  assign out_res.raw_frame      = raw_r;

endmodule

// ===== rtl/core/rc5_ir_frame_decoder.sv =====
// top level of the rc5 infrared frame decoder.
// depends on rc5_pkg, rc5_chan_if, rc5_cfg_regs, rc5_win_match, rc5_frame_acc.
//
//   port group  direction  transaction
//   in_sym      sink       one captured pulse symbol (two durations, level, last mark)
//   out_res     source     one frame result, on the last symbol only
//   p*          apb slave  half period at 0x0, tolerance at 0x4
//
// one symbol per cycle sustained, unless a closing symbol waits for a stalled
// result; each symbol passes through the symbol register, where the frame state
// is updated, before a closing symbol's result is loaded into the result register.
// the window compares sit ahead of the symbol register.
// reset is synchronous on rst_n and clears frame state and the last-good record.
// a stalled result only holds back a symbol that closes another frame.
module rc5_ir_frame_decoder #(
  parameter int MAX_SYMBOLS = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  rc5_sym_if.sink     in_sym,
  rc5_res_if.source   out_res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rc5_pkg::*;

  logic [PeriodW-1:0] half_period;
  logic [PeriodW-1:0] tolerance;
  rc5_match_t         match;

  rc5_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .half_period (half_period),
    .tolerance   (tolerance)
  );

  rc5_win_match u_win (
    .first_duration  (in_sym.first_duration),
    .second_duration (in_sym.second_duration),
    .half_period     (half_period),
    .tolerance       (tolerance),
    .match           (match)
  );

  rc5_frame_acc #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_sym.valid),
    .in_ready (in_sym.ready),
    .in_match (match),
    .in_level (in_sym.first_level),
    .in_last  (in_sym.last_symbol),
    .out_res  (out_res)
  );

endmodule
